// ----- src/vzc_pkg.sv -----
package vzc_pkg;

    localparam int GROUP_BITS   = 7;
    localparam int NARROW_W     = 32;
    localparam int WIDE_W       = 64;
    localparam int NARROW_LIMIT = 5;
    localparam int WIDE_LIMIT   = 10;
    localparam int CNT_W        = 4;
    // bits the final group keeps in each width
    localparam int NARROW_TAIL  = NARROW_W - GROUP_BITS * (NARROW_LIMIT - 1);
    localparam int WIDE_TAIL    = WIDE_W - GROUP_BITS * (WIDE_LIMIT - 1);
    // decode accumulator holds every group of a wide value
    localparam int ACC_W        = GROUP_BITS * WIDE_LIMIT;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [WIDE_W-1:0] value;
        logic [7:0]        in_byte;
        logic              wide;
        logic              zigzag;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              is_byte;
        logic              last;
        logic [WIDE_W-1:0] decoded;
    } t_out_item;

endpackage

// ----- src/vzc_enc.sv -----
module vzc_enc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  vzc_pkg::t_in_item i_item,
    output logic              o_busy,
    output logic              o_res_valid,
    output vzc_pkg::t_out_item o_res,
    input  logic              i_res_ready
);

    logic                         r_busy;
    logic [vzc_pkg::WIDE_W-1:0]   r_v;
    logic [vzc_pkg::WIDE_W-1:0]   n_v;
    logic [vzc_pkg::NARROW_W-1:0] v32;
    logic                         more;

    // zigzag: (n << 1) ^ sign-fill at the selected width
    always_comb begin
        v32 = i_item.value[vzc_pkg::NARROW_W-1:0];
        if (i_item.wide) begin
            n_v = i_item.value;
            if (i_item.zigzag) begin
                n_v = {i_item.value[vzc_pkg::WIDE_W-2:0], 1'b0}
                    ^ {vzc_pkg::WIDE_W{i_item.value[vzc_pkg::WIDE_W-1]}};
            end
        end else begin
            if (i_item.zigzag) begin
                v32 = {v32[vzc_pkg::NARROW_W-2:0], 1'b0}
                    ^ {vzc_pkg::NARROW_W{v32[vzc_pkg::NARROW_W-1]}};
            end
            n_v = {{(vzc_pkg::WIDE_W-vzc_pkg::NARROW_W){1'b0}}, v32};
        end
    end

    assign more = |r_v[vzc_pkg::WIDE_W-1:vzc_pkg::GROUP_BITS];

    always_comb begin
        o_res          = '0;
        o_res.out_byte = {more, r_v[vzc_pkg::GROUP_BITS-1:0]};
        o_res.is_byte  = 1'b1;
        o_res.last     = !more;
    end

    assign o_res_valid = r_busy;
    assign o_busy      = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_v    <= n_v;
        end else if (r_busy && i_res_ready) begin
            r_busy <= more;
            r_v    <= r_v >> vzc_pkg::GROUP_BITS;
        end
    end

endmodule

// ----- src/vzc_dec.sv -----
module vzc_dec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  vzc_pkg::t_in_item i_item,
    output logic              o_busy,
    output logic              o_res_valid,
    output vzc_pkg::t_out_item o_res,
    input  logic              i_res_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALIGN,
        S_HOLD
    } t_state;

    localparam logic [vzc_pkg::GROUP_BITS-1:0] NARROW_MASK =
        vzc_pkg::GROUP_BITS'((1 << vzc_pkg::NARROW_TAIL) - 1);
    localparam logic [vzc_pkg::GROUP_BITS-1:0] WIDE_MASK =
        vzc_pkg::GROUP_BITS'((1 << vzc_pkg::WIDE_TAIL) - 1);

    t_state                            r_state;
    logic [vzc_pkg::ACC_W-1:0]         r_acc;
    logic [vzc_pkg::CNT_W-1:0]         r_count;
    logic [vzc_pkg::CNT_W-1:0]         r_left;
    logic                              r_wide;
    logic                              r_zz;
    logic [vzc_pkg::CNT_W-1:0]         n_count;
    logic [vzc_pkg::CNT_W-1:0]         limit;
    logic [vzc_pkg::GROUP_BITS-1:0]    grp;
    logic                              fin;
    logic [vzc_pkg::WIDE_W-1:0]        a;
    logic [vzc_pkg::NARROW_W-1:0]      r32;
    logic [vzc_pkg::WIDE_W-1:0]        result;

    // drop group bits that land past the width
    function automatic logic [vzc_pkg::GROUP_BITS-1:0] group_keep(
        input logic [vzc_pkg::GROUP_BITS-1:0] g,
        input logic [vzc_pkg::CNT_W-1:0]      k,
        input logic                           w
    );
        logic [vzc_pkg::GROUP_BITS-1:0] m;
        if (w) begin
            if (k < vzc_pkg::CNT_W'(vzc_pkg::WIDE_LIMIT - 1)) m = '1;
            else if (k == vzc_pkg::CNT_W'(vzc_pkg::WIDE_LIMIT - 1)) m = WIDE_MASK;
            else m = '0;
        end else begin
            if (k < vzc_pkg::CNT_W'(vzc_pkg::NARROW_LIMIT - 1)) m = '1;
            else if (k == vzc_pkg::CNT_W'(vzc_pkg::NARROW_LIMIT - 1)) m = NARROW_MASK;
            else m = '0;
        end
        return g & m;
    endfunction

    always_comb begin
        grp     = group_keep(i_item.in_byte[vzc_pkg::GROUP_BITS-1:0], r_count, i_item.wide);
        n_count = r_count + vzc_pkg::CNT_W'(1);
        limit   = i_item.wide ? vzc_pkg::CNT_W'(vzc_pkg::WIDE_LIMIT)
                              : vzc_pkg::CNT_W'(vzc_pkg::NARROW_LIMIT);
        fin     = !i_item.in_byte[7] || (n_count >= limit);
    end

    // groups enter at the top; alignment shifts group 0 down to bit 0
    always_comb begin
        a   = r_acc[vzc_pkg::WIDE_W-1:0];
        r32 = a[vzc_pkg::NARROW_W-1:0];
        if (r_wide) begin
            result = a;
            if (r_zz) begin
                result = (a >> 1) ^ {vzc_pkg::WIDE_W{a[0]}};
            end
        end else if (r_zz) begin
            r32    = (r32 >> 1) ^ {vzc_pkg::NARROW_W{r32[0]}};
            result = {{(vzc_pkg::WIDE_W-vzc_pkg::NARROW_W){r32[vzc_pkg::NARROW_W-1]}}, r32};
        end else begin
            result = {{(vzc_pkg::WIDE_W-vzc_pkg::NARROW_W){1'b0}}, r32};
        end
    end

    always_comb begin
        o_res         = '0;
        o_res.is_byte = 1'b0;
        o_res.last    = 1'b1;
        o_res.decoded = result;
    end

    assign o_res_valid = (r_state == S_HOLD);
    assign o_busy      = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_count <= '0;
            r_left  <= '0;
            r_wide  <= 1'b0;
            r_zz    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_acc   <= {grp, r_acc[vzc_pkg::ACC_W-1:vzc_pkg::GROUP_BITS]};
                        r_count <= n_count;
                        if (fin) begin
                            r_left  <= vzc_pkg::CNT_W'(vzc_pkg::WIDE_LIMIT) - n_count;
                            r_wide  <= i_item.wide;
                            r_zz    <= i_item.zigzag;
                            r_state <= S_ALIGN;
                        end
                    end
                end
                S_ALIGN: begin
                    if (r_left != '0) begin
                        r_acc  <= r_acc >> vzc_pkg::GROUP_BITS;
                        r_left <= r_left - vzc_pkg::CNT_W'(1);
                    end else begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (i_res_ready) begin
                        r_acc   <= '0;
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/varint_zigzag_codec_unit.sv -----
// channel  ports                                 item
// input    i_in_valid / o_in_ready / i_in_item   t_in_item: opcode, value, in_byte, wide, zigzag
// output   o_out_valid / i_out_ready / o_out_item t_out_item: out_byte, is_byte, last, decoded
//
// Encode: 1 to 10 output bytes, one per cycle unless the output stalls, from a 7-bit digit shift register;
//   the next item is taken once the last byte has entered the output register.
// Decode: a byte that continues the value is taken while the unit stays idle. The final byte
//   starts an alignment by 10 - n groups (n groups received), then the result is held.
// Reset (synchronous, i_rst_n low) clears the accumulator, counters and valids.
// A stalled output freezes the encoder and holds the decoder's result; input waits while a unit is busy.
module varint_zigzag_codec_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  vzc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vzc_pkg::t_out_item o_out_item
);

    logic               enc_busy;
    logic               enc_res_valid;
    vzc_pkg::t_out_item enc_res;
    logic               dec_busy;
    logic               dec_res_valid;
    vzc_pkg::t_out_item dec_res;
    logic               take;
    logic               in_acc;
    logic               r_out_valid;
    vzc_pkg::t_out_item r_out_item;

    assign o_in_ready = !enc_busy && !dec_busy;
    assign in_acc     = i_in_valid && o_in_ready;
    assign take       = !r_out_valid || i_out_ready;

    vzc_enc u_enc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc && (i_in_item.opcode == vzc_pkg::OP_ENCODE)),
        .i_item      (i_in_item),
        .o_busy      (enc_busy),
        .o_res_valid (enc_res_valid),
        .o_res       (enc_res),
        .i_res_ready (take)
    );

    vzc_dec u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc && (i_in_item.opcode == vzc_pkg::OP_DECODE)),
        .i_item      (i_in_item),
        .o_busy      (dec_busy),
        .o_res_valid (dec_res_valid),
        .o_res       (dec_res),
        .i_res_ready (take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= enc_res_valid || dec_res_valid;
            r_out_item  <= enc_res_valid ? enc_res : dec_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(enc_res_valid && dec_res_valid))
        else $error("both units offer a result");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!enc_res_valid && !dec_res_valid))
        else $error("input ready while a result is pending");

    a_dec_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.is_byte) |-> (o_out_item.last && o_out_item.out_byte == 8'd0))
        else $error("decoded item malformed");

endmodule
